>>> rtl/pssel_pkg.sv
`default_nettype none

package pssel_pkg;

   // fixed field widths of the ports
   localparam int CFG_W      = 17;
   localparam int IDX_OUT_W  = 16;
   localparam int RAND_IN_W  = 31;

   // register indexes
   localparam logic REG_TOTAL_COUNT  = 1'b0;
   localparam logic REG_SELECT_COUNT = 1'b1;

   // item operations
   localparam logic OP_START = 1'b0;
   localparam logic OP_DRAW  = 1'b1;

   // table write sources
   localparam logic [1:0] WR_NONE  = 2'd0;
   localparam logic [1:0] WR_SWEEP = 2'd1;
   localparam logic [1:0] WR_AT_J  = 2'd2;
   localparam logic [1:0] WR_AT_I  = 2'd3;

   // table read addresses
   localparam logic RD_AT_I = 1'b0;
   localparam logic RD_AT_J = 1'b1;

   // divider operand selection
   localparam logic DIV_SPAN = 1'b0;
   localparam logic DIV_DRAW = 1'b1;

   // result kinds
   localparam logic OUT_BLANK = 1'b0;
   localparam logic OUT_DRAW  = 1'b1;

   typedef struct packed {
      logic       take_item;
      logic       begin_sel;
      logic       div_start;
      logic       div_op;
      logic       latch_d;
      logic       latch_j;
      logic       rd_en;
      logic       rd_sel;
      logic       latch_ti;
      logic       latch_tj;
      logic [1:0] wr_mode;
      logic       pos_inc;
      logic       out_load;
      logic       out_kind;
   } cmd_type;

   typedef struct packed {
      logic is_draw;
      logic draw_ok;
      logic sweep_last;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/partial_shuffle_index_selector.sv
// Picks select_count distinct indices out of total_count by a partial in-place random
// shuffle over an index table held in a single-port-write, registered-read RAM of
// MAX_COUNT entries. Every item gives exactly one result. A start item (op 0) takes
// the registers, fills the table with the identity permutation one entry a cycle and
// then returns a blank result. A draw item (op 1) runs two divisions on a shared
// one-bit-per-step divider of max(RANDOM_BITS, clog2(MAX_COUNT + 1)) + 1 steps each
// (the random maximum divided by N - i, then r divided by that quotient plus one),
// then reads and swaps two table entries. A draw past the K-th, or before any start,
// returns a blank result. A stalled result side holds the item until the output
// register is free. One item is worked at a time; the next is taken while the
// previous result still waits in the output register. The table needs no clearing
// after reset; register writes take effect at the next start.
`default_nettype none

module partial_shuffle_index_selector #(
   parameter int MAX_COUNT   = 65536,
   parameter int RANDOM_BITS = 31
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_op,
   input  wire logic [pssel_pkg::RAND_IN_W-1:0]    req_random_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [pssel_pkg::IDX_OUT_W-1:0]    rsp_selected_index,
   output logic                                    rsp_index_valid,
   output logic                                    rsp_last_index,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic                               csr_index,
   input  wire logic [pssel_pkg::CFG_W-1:0]        csr_wdata
);

   pssel_pkg::cmd_type    cmd;
   pssel_pkg::status_type status;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;

   pssel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pssel_dp #(
      .MAX_COUNT   (MAX_COUNT),
      .RANDOM_BITS (RANDOM_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_random_value   (req_random_value),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_selected_index (rsp_selected_index),
      .rsp_index_valid    (rsp_index_valid),
      .rsp_last_index     (rsp_last_index)
   );

`ifndef SYNTHESIS
   // an accepted item holds off the next one in the cycle after it is taken
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item taken while previous still in work");

   // last flag only rides on a produced index
   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_index) |-> rsp_index_valid)
      else $error("last flag without an index");

   // blank results carry zero payload
   a_blank_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_index_valid) |->
         (rsp_selected_index == '0) && !rsp_last_index)
      else $error("blank result with non-zero fields");
`endif

endmodule

`default_nettype wire

>>> rtl/pssel_ram.sv
`default_nettype none

module pssel_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/pssel_div.sv
`default_nettype none

module pssel_div #(
   parameter int W = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic      [W-1:0] quotient
);

   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quot_ff, quot_in;
   logic [W-1:0]     dsr_ff, dsr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [W:0]       shifted;
   logic [W:0]       diff;
   logic             fits;

   // one quotient bit a step, restoring
   assign shifted = {rem_ff, quot_ff[W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = (shifted >= {1'b0, dsr_ff});

   always_comb begin
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quot_in  = dividend;
         dsr_in   = divisor;
         count_in = CNT_W'(W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[W-1:0] : shifted[W-1:0];
         quot_in  = {quot_ff[W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

>>> rtl/pssel_ctrl.sv
`default_nettype none

module pssel_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire pssel_pkg::status_type status,
   output pssel_pkg::cmd_type        cmd
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_DECODE     = 4'd1;
   localparam logic [3:0] S_SWEEP      = 4'd2;
   localparam logic [3:0] S_DIV_SPAN   = 4'd3;
   localparam logic [3:0] S_DIV_LOAD   = 4'd4;
   localparam logic [3:0] S_DIV_DRAW   = 4'd5;
   localparam logic [3:0] S_READ_I     = 4'd6;
   localparam logic [3:0] S_READ_J     = 4'd7;
   localparam logic [3:0] S_WRITE_J    = 4'd8;
   localparam logic [3:0] S_WRITE_I    = 4'd9;
   localparam logic [3:0] S_EMIT_BLANK = 4'd10;
   localparam logic [3:0] S_EMIT_DRAW  = 4'd11;

   logic [3:0] state_ff, state_in;

   // take a new item only when idle
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.wr_mode  = pssel_pkg::WR_NONE;
      cmd.div_op   = pssel_pkg::DIV_SPAN;
      cmd.rd_sel   = pssel_pkg::RD_AT_I;
      cmd.out_kind = pssel_pkg::OUT_BLANK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!status.is_draw) begin
               cmd.begin_sel = 1'b1;
               state_in      = S_SWEEP;
            end else if (status.draw_ok) begin
               cmd.div_start = 1'b1;
               cmd.div_op    = pssel_pkg::DIV_SPAN;
               state_in      = S_DIV_SPAN;
            end else begin
               state_in = S_EMIT_BLANK;
            end
         end
         S_SWEEP: begin
            cmd.wr_mode = pssel_pkg::WR_SWEEP;
            if (status.sweep_last) begin
               state_in = S_EMIT_BLANK;
            end
         end
         S_DIV_SPAN: begin
            if (status.div_done) begin
               cmd.latch_d = 1'b1;
               state_in    = S_DIV_LOAD;
            end
         end
         S_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = pssel_pkg::DIV_DRAW;
            state_in      = S_DIV_DRAW;
         end
         S_DIV_DRAW: begin
            if (status.div_done) begin
               cmd.latch_j = 1'b1;
               state_in    = S_READ_I;
            end
         end
         S_READ_I: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = pssel_pkg::RD_AT_I;
            state_in   = S_READ_J;
         end
         S_READ_J: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = pssel_pkg::RD_AT_J;
            cmd.latch_ti = 1'b1;
            state_in     = S_WRITE_J;
         end
         S_WRITE_J: begin
            cmd.latch_tj = 1'b1;
            cmd.wr_mode  = pssel_pkg::WR_AT_J;
            state_in     = S_WRITE_I;
         end
         S_WRITE_I: begin
            cmd.wr_mode = pssel_pkg::WR_AT_I;
            cmd.pos_inc = 1'b1;
            state_in    = S_EMIT_DRAW;
         end
         S_EMIT_BLANK: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = pssel_pkg::OUT_BLANK;
               state_in     = S_IDLE;
            end
         end
         S_EMIT_DRAW: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = pssel_pkg::OUT_DRAW;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/pssel_dp.sv
`default_nettype none

module pssel_dp #(
   parameter int MAX_COUNT   = 65536,
   parameter int RANDOM_BITS = 31
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pssel_pkg::cmd_type                  cmd,
   output pssel_pkg::status_type                    status,
   input  wire logic                                req_op,
   input  wire logic [pssel_pkg::RAND_IN_W-1:0]     req_random_value,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_index,
   input  wire logic [pssel_pkg::CFG_W-1:0]         csr_wdata,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [pssel_pkg::IDX_OUT_W-1:0]     rsp_selected_index,
   output logic                                     rsp_index_valid,
   output logic                                     rsp_last_index
);

   localparam int CNT_W  = $clog2(MAX_COUNT + 1);
   localparam int ADDR_W = $clog2(MAX_COUNT);
   localparam int CMP_W  = (CNT_W > pssel_pkg::CFG_W) ? CNT_W : pssel_pkg::CFG_W;
   localparam int DIV_W  = ((RANDOM_BITS > CNT_W) ? RANDOM_BITS : CNT_W) + 1;
   localparam int IW     = pssel_pkg::IDX_OUT_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_COUNT);
   localparam logic [DIV_W-1:0] RMAX =
      {{(DIV_W - RANDOM_BITS){1'b0}}, {RANDOM_BITS{1'b1}}};

   logic [pssel_pkg::CFG_W-1:0] total_ff, select_ff;
   logic                        op_ff;
   logic [RANDOM_BITS-1:0]      rand_ff;
   logic [CNT_W-1:0]            n_ff, k_ff, pos_ff;
   logic [ADDR_W-1:0]           sweep_ff;
   logic [DIV_W-1:0]            d_ff;
   logic [ADDR_W-1:0]           j_ff, ti_ff, tj_ff;
   logic [IW-1:0]               idx_out_ff;
   logic                        valid_out_ff, last_out_ff, rsp_valid_ff;

   logic [RANDOM_BITS+pssel_pkg::RAND_IN_W-1:0] rand_ext;
   logic [CMP_W-1:0]  total_ext, select_ext, n_cmp, k_cmp;
   logic [CNT_W-1:0]  span;
   logic [DIV_W-1:0]  div_dividend, div_divisor, div_quot;
   logic              div_done;
   logic [DIV_W:0]    j_sum, j_full;
   logic [IW+ADDR_W-1:0] tj_ext;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_wr_data, ram_rd_addr, ram_rd_data;

   // use only the low RANDOM_BITS bits of the random value
   assign rand_ext = {{RANDOM_BITS{1'b0}}, req_random_value};

   // effective N and K from the registers
   assign total_ext  = CMP_W'(total_ff);
   assign select_ext = CMP_W'(select_ff);
   always_comb begin
      if (total_ext == '0) begin
         n_cmp = CMP_W'(1);
      end else if (total_ext > MAX_CMP) begin
         n_cmp = MAX_CMP;
      end else begin
         n_cmp = total_ext;
      end
      k_cmp = (select_ext > n_cmp) ? n_cmp : select_ext;
   end

   // divider operands: first the random maximum / span, then r / d
   assign span         = n_ff - pos_ff;
   assign div_dividend = (cmd.div_op == pssel_pkg::DIV_SPAN) ? RMAX : DIV_W'(rand_ff);
   assign div_divisor  = (cmd.div_op == pssel_pkg::DIV_SPAN) ? DIV_W'(span) : d_ff;

   pssel_div #(
      .W(DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // swap partner, clamped to N - 1
   assign j_sum  = (DIV_W + 1)'(pos_ff) + (DIV_W + 1)'(div_quot);
   assign j_full = (j_sum >= (DIV_W + 1)'(n_ff)) ? (DIV_W + 1)'(n_ff - 1'b1) : j_sum;

   // table port selection
   always_comb begin
      ram_wr_en   = (cmd.wr_mode != pssel_pkg::WR_NONE);
      ram_wr_addr = sweep_ff;
      ram_wr_data = sweep_ff;
      case (cmd.wr_mode)
         pssel_pkg::WR_SWEEP: begin
            ram_wr_addr = sweep_ff;
            ram_wr_data = sweep_ff;
         end
         pssel_pkg::WR_AT_J: begin
            ram_wr_addr = j_ff;
            ram_wr_data = ti_ff;
         end
         pssel_pkg::WR_AT_I: begin
            ram_wr_addr = pos_ff[ADDR_W-1:0];
            ram_wr_data = tj_ff;
         end
         default: begin
            ram_wr_addr = sweep_ff;
            ram_wr_data = sweep_ff;
         end
      endcase
      ram_rd_addr = (cmd.rd_sel == pssel_pkg::RD_AT_I) ? pos_ff[ADDR_W-1:0] : j_ff;
   end

   pssel_ram #(
      .WIDTH(ADDR_W),
      .DEPTH(MAX_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= pssel_pkg::CFG_W'(65536);
         select_ff    <= '0;
         n_ff         <= CNT_W'(1);
         k_ff         <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == pssel_pkg::REG_TOTAL_COUNT)) begin
            total_ff <= csr_wdata;
         end
         if (csr_valid && (csr_index == pssel_pkg::REG_SELECT_COUNT)) begin
            select_ff <= csr_wdata;
         end
         if (cmd.begin_sel) begin
            n_ff   <= n_cmp[CNT_W-1:0];
            k_ff   <= k_cmp[CNT_W-1:0];
            pos_ff <= '0;
         end else if (cmd.pos_inc) begin
            pos_ff <= pos_ff + 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         op_ff   <= req_op;
         rand_ff <= rand_ext[RANDOM_BITS-1:0];
      end
      if (cmd.begin_sel) begin
         sweep_ff <= '0;
      end else if (cmd.wr_mode == pssel_pkg::WR_SWEEP) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
      if (cmd.latch_d) begin
         d_ff <= div_quot + 1'b1;
      end
      if (cmd.latch_j) begin
         j_ff <= j_full[ADDR_W-1:0];
      end
      if (cmd.latch_ti) begin
         ti_ff <= ram_rd_data;
      end
      if (cmd.latch_tj) begin
         tj_ff <= ram_rd_data;
      end
      if (cmd.out_load) begin
         if (cmd.out_kind == pssel_pkg::OUT_DRAW) begin
            idx_out_ff   <= tj_ext[IW-1:0];
            valid_out_ff <= 1'b1;
            last_out_ff  <= (pos_ff == k_ff);
         end else begin
            idx_out_ff   <= '0;
            valid_out_ff <= 1'b0;
            last_out_ff  <= 1'b0;
         end
      end
   end

   assign tj_ext = {{IW{1'b0}}, tj_ff};

   // status back to the controller
   assign status.is_draw    = (op_ff == pssel_pkg::OP_DRAW);
   assign status.draw_ok    = (pos_ff < k_ff);
   assign status.sweep_last = (CNT_W'(sweep_ff) == (n_ff - 1'b1));
   assign status.div_done   = div_done;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_selected_index = idx_out_ff;
   assign rsp_index_valid    = valid_out_ff;
   assign rsp_last_index     = last_out_ff;

endmodule

`default_nettype wire

>>> verif/tb_partial_shuffle_index_selector.sv
`default_nettype none

module tb_partial_shuffle_index_selector;

   localparam int MAX_COUNT   = 65536;
   localparam int RANDOM_BITS = 31;
   localparam int ITEMS       = 450;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 800;

   logic                            clock            = 1'b0;
   logic                            reset            = 1'b1;
   logic                            req_valid        = 1'b0;
   logic                            req_stall;
   logic                            req_op           = pssel_pkg::OP_START;
   logic [pssel_pkg::RAND_IN_W-1:0] req_random_value = '0;
   logic                            rsp_valid;
   logic                            rsp_stall        = 1'b0;
   logic [pssel_pkg::IDX_OUT_W-1:0] rsp_selected_index;
   logic                            rsp_index_valid;
   logic                            rsp_last_index;
   logic                            csr_valid        = 1'b0;
   logic                            csr_ready;
   logic                            csr_index        = pssel_pkg::REG_TOTAL_COUNT;
   logic [pssel_pkg::CFG_W-1:0]     csr_wdata        = '0;

   int items_sent  = 0;
   int pressure_at = 32'h7FFF_FFFF;
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   int cycles      = 0;

   typedef struct packed {
      logic [pssel_pkg::IDX_OUT_W-1:0] index;
      logic                            valid;
      logic                            last;
   } pick_type;

   // Shadow of the shuffle: permutation, latched N and K, draw position
   class shuffle_scoreboard;
      bit [pssel_pkg::IDX_OUT_W-1:0] perm [MAX_COUNT];
      bit [pssel_pkg::CFG_W-1:0]     total_reg;
      bit [pssel_pkg::CFG_W-1:0]     select_reg;
      int unsigned                   n_live;
      int unsigned                   k_live;
      int unsigned                   pos;
      pick_type                      expected_picks [$];
      int                            errors;

      function new();
         total_reg  = pssel_pkg::CFG_W'(MAX_COUNT);
         select_reg = '0;
         n_live     = 1;
         k_live     = 0;
         pos        = 0;
         errors     = 0;
      endfunction

      function void write_reg(logic idx, logic [pssel_pkg::CFG_W-1:0] data);
         if (idx == pssel_pkg::REG_TOTAL_COUNT) total_reg = data;
         else select_reg = data;
      endfunction

      // Work out the pick that one accepted item causes
      function void note_item(logic op, logic [pssel_pkg::RAND_IN_W-1:0] rv);
         pick_type                      p;
         int unsigned                   rmax;
         int unsigned                   r;
         int unsigned                   j;
         int unsigned                   a;
         bit [pssel_pkg::IDX_OUT_W-1:0] t;
         p    = '0;
         rmax = (32'd1 << RANDOM_BITS) - 1;
         r    = rv & rmax;
         if (op == pssel_pkg::OP_START) begin
            // latch N and K, load the identity permutation
            if (total_reg == 0) n_live = 1;
            else if (total_reg > MAX_COUNT) n_live = MAX_COUNT;
            else n_live = total_reg;
            k_live = (select_reg > n_live) ? n_live : select_reg;
            for (a = 0; a < n_live; a++) perm[a] = pssel_pkg::IDX_OUT_W'(a);
            pos = 0;
         end else if (pos < k_live && pos < n_live) begin
            j = pos + r / (rmax / (n_live - pos) + 1);
            if (j >= n_live) j = n_live - 1;
            t         = perm[pos];
            perm[pos] = perm[j];
            perm[j]   = t;
            p.index   = perm[pos];
            p.valid   = 1'b1;
            p.last    = (pos + 1 == k_live);
            pos++;
         end
         expected_picks.push_back(p);
      endfunction

      function void check_result(pick_type got);
         pick_type want;
         if (expected_picks.size() == 0) begin
            $display("%0t: unexpected result: index %0d valid %0b last %0b",
                     $time, got.index, got.valid, got.last);
            errors++;
            return;
         end
         want = expected_picks.pop_front();
         if (got.index !== want.index) begin
            $display("%0t: selected_index expected %0d actual %0d",
                     $time, want.index, got.index);
            errors++;
         end
         if (got.valid !== want.valid) begin
            $display("%0t: index_valid expected %0b actual %0b",
                     $time, want.valid, got.valid);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_index expected %0b actual %0b",
                     $time, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   shuffle_scoreboard sb;

   partial_shuffle_index_selector #(
      .MAX_COUNT   (MAX_COUNT),
      .RANDOM_BITS (RANDOM_BITS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_random_value   (req_random_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_selected_index (rsp_selected_index),
      .rsp_index_valid    (rsp_index_valid),
      .rsp_last_index     (rsp_last_index),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Check every item taken on the result side
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_selected_index, rsp_index_valid, rsp_last_index});
   end

   // Stall the result side at random; hold it off once for a long stretch
   always @(negedge clock) begin
      if (!hold_done && items_sent >= pressure_at) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) <
                       ((items_sent < 150) ? 65 : (items_sent < 300) ? 33 : 0));
      end
   end

   function automatic logic [pssel_pkg::RAND_IN_W-1:0] draw_value();
      case ($urandom_range(19))
         0: return '0;
         1: return '1;
         default: return pssel_pkg::RAND_IN_W'($urandom());
      endcase
   endfunction

   // Offer one item, with random gaps ahead of it, and hold it until taken
   task automatic send_item(input logic op, input logic [pssel_pkg::RAND_IN_W-1:0] rv);
      int pct;
      pct = (items_sent < 150) ? 33 : (items_sent < 300) ? 65 : 0;
      while ($urandom_range(99) < pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_random_value <= rv;
      do @(posedge clock); while (req_stall);
      sb.note_item(op, rv);
      items_sent++;
      @(negedge clock);
   endtask

   // Drop the request and wait until every pick has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_picks.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [pssel_pkg::CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [pssel_pkg::CFG_W-1:0] total,
                            input logic [pssel_pkg::CFG_W-1:0] sel);
      wait_idle();
      write_csr(pssel_pkg::REG_TOTAL_COUNT, total);
      write_csr(pssel_pkg::REG_SELECT_COUNT, sel);
   endtask

   // Random selections: mostly complete, some cut short, some running past K
   task automatic run_random(input int upto);
      int n;
      int k;
      int draws;
      while (items_sent < upto) begin
         if ($urandom_range(9) < 6) begin
            case ($urandom_range(9))
               0:       n = $urandom_range(0, 2);
               1, 2:    n = $urandom_range(25, 300);
               default: n = $urandom_range(1, 24);
            endcase
            k = (n > 24) ? $urandom_range(0, 30) : $urandom_range(0, n + 2);
            configure(pssel_pkg::CFG_W'(n), pssel_pkg::CFG_W'(k));
         end
         send_item(pssel_pkg::OP_START, draw_value());
         if ($urandom_range(9) < 2) draws = $urandom_range(0, sb.k_live);
         else draws = sb.k_live + $urandom_range(0, 2);
         repeat (draws) send_item(pssel_pkg::OP_DRAW, draw_value());
      end
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // draw before any start gives a blank pick
      send_item(pssel_pkg::OP_DRAW, '1);

      // total of zero reads as one; draw past K is blank
      configure('0, 1);
      send_item(pssel_pkg::OP_START, '0);
      send_item(pssel_pkg::OP_DRAW, '1);
      send_item(pssel_pkg::OP_DRAW, '0);

      // select clamped to total; register writes mid-selection wait for the next start
      configure(5, '1);
      send_item(pssel_pkg::OP_START, '1);
      send_item(pssel_pkg::OP_DRAW, '0);
      send_item(pssel_pkg::OP_DRAW, '1);
      wait_idle();
      write_csr(pssel_pkg::REG_SELECT_COUNT, 1);
      write_csr(pssel_pkg::REG_TOTAL_COUNT, 2);
      send_item(pssel_pkg::OP_DRAW, draw_value());
      send_item(pssel_pkg::OP_DRAW, draw_value());
      send_item(pssel_pkg::OP_DRAW, '1);
      send_item(pssel_pkg::OP_DRAW, draw_value());

      // total above the table size saturates
      configure('1, 3);
      send_item(pssel_pkg::OP_START, draw_value());
      send_item(pssel_pkg::OP_DRAW, '1);
      send_item(pssel_pkg::OP_DRAW, '0);
      send_item(pssel_pkg::OP_DRAW, draw_value());
      send_item(pssel_pkg::OP_DRAW, draw_value());

      // nothing to select
      configure(7, 0);
      send_item(pssel_pkg::OP_START, draw_value());
      send_item(pssel_pkg::OP_DRAW, draw_value());

      // restart in the middle of a selection
      configure(2, 2);
      send_item(pssel_pkg::OP_START, draw_value());
      send_item(pssel_pkg::OP_DRAW, draw_value());
      send_item(pssel_pkg::OP_START, draw_value());
      send_item(pssel_pkg::OP_DRAW, draw_value());
      send_item(pssel_pkg::OP_DRAW, draw_value());

      run_random(340);

      // keep offering draws while the result side holds off
      configure(30, 30);
      pressure_at = items_sent;
      send_item(pssel_pkg::OP_START, draw_value());
      repeat (30) send_item(pssel_pkg::OP_DRAW, draw_value());

      run_random(ITEMS);

      wait_idle();
      repeat (200) @(negedge clock);
      if (sb.errors == 0 && sb.expected_picks.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
